// ===== design/pbd_pkg.sv =====
// pbd_pkg: shared types and constants for the palette bayer dither mapper
// holds the fixed palette, the 4x4 bayer matrix and the pipeline payload structs
// no dependencies
package pbd_pkg;

	localparam int PAL_N   = 6;
	localparam int IDX_W   = 3;
	localparam int SQ_W    = 16;
	localparam int DIST_W  = 20;
	localparam int SUM_W   = DIST_W + 1;
	localparam int THR_W   = 5;
	localparam int CODE_W  = 4;
	localparam int CFG_W   = 4;
	localparam int CFG_IDX_W = 3;

	// palette in priority order: black, white, yellow, red, blue, green
	localparam logic [7:0] PAL_R [PAL_N] = '{8'd0, 8'd255, 8'd251, 8'd251, 8'd0,  8'd12};
	localparam logic [7:0] PAL_G [PAL_N] = '{8'd0, 8'd255, 8'd246, 8'd4,   8'd53, 8'd108};
	localparam logic [7:0] PAL_B [PAL_N] = '{8'd0, 8'd255, 8'd0,   8'd0,   8'd214, 8'd13};

	// reset value of each entry's panel code
	localparam logic [CODE_W-1:0] CODE_RST [PAL_N] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6};

	// bayer threshold, indexed [row][col]
	localparam logic [3:0] BAYER [4][4] = '{
		'{4'd0,  4'd8,  4'd2,  4'd10},
		'{4'd12, 4'd4,  4'd14, 4'd6},
		'{4'd3,  4'd11, 4'd1,  4'd9},
		'{4'd15, 4'd7,  4'd13, 4'd5}
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DITHER = 3'd0,
		REG_BLACK  = 3'd1,
		REG_WHITE  = 3'd2,
		REG_YELLOW = 3'd3,
		REG_RED    = 3'd4,
		REG_BLUE   = 3'd5,
		REG_GREEN  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] col_phase;
		logic [1:0] row_phase;
	} pix_t;

	// running nearest / second-nearest candidates carried along the chain
	typedef struct packed {
		pix_t              pix;
		logic [DIST_W-1:0] best_d;
		logic [DIST_W-1:0] next_d;
		logic [IDX_W-1:0]  first;
		logic [IDX_W-1:0]  second;
	} cand_t;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

// ===== design/pbd_cell.sv =====
// pbd_cell: one palette entry of the distance chain
// stage 1 squares the channel differences, stage 2 weights, sums and ranks
// depends on pbd_pkg
module pbd_cell import pbd_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  cand_t in_cand,
	output logic  out_valid,
	input  logic  out_ready,
	output cand_t out_cand
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic              valid_s1, valid_s2;
	logic              load_s1, load_s2;
	logic [SQ_W-1:0]   sq_r_s1, sq_g_s1, sq_b_s1;
	cand_t             cand_s1, cand_s2;
	logic [7:0]        dr, dg, db;
	logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
	logic [DIST_W-1:0] wdist;
	cand_t             upd;

	assign load_s2  = !valid_s2 || out_ready;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;

	always_comb begin
		dr   = (in_cand.pix.red   >= PAL_R[IDX]) ? in_cand.pix.red   - PAL_R[IDX]
		                                          : PAL_R[IDX] - in_cand.pix.red;
		dg   = (in_cand.pix.green >= PAL_G[IDX]) ? in_cand.pix.green - PAL_G[IDX]
		                                          : PAL_G[IDX] - in_cand.pix.green;
		db   = (in_cand.pix.blue  >= PAL_B[IDX]) ? in_cand.pix.blue  - PAL_B[IDX]
		                                          : PAL_B[IDX] - in_cand.pix.blue;
		sq_r = SQ_W'(dr) * SQ_W'(dr);
		sq_g = SQ_W'(dg) * SQ_W'(dg);
		sq_b = SQ_W'(db) * SQ_W'(db);
	end

	// strict less-than keeps the earlier entry on ties
	always_comb begin
		wdist = DIST_W'(sq_r_s1) * DIST_W'(3) + DIST_W'(sq_g_s1) * DIST_W'(6)
		      + DIST_W'(sq_b_s1);
		upd   = cand_s1;
		if (wdist < cand_s1.best_d) begin
			upd.next_d = cand_s1.best_d;
			upd.second = cand_s1.first;
			upd.best_d = wdist;
			upd.first  = MY_IDX;
		end else if (wdist < cand_s1.next_d) begin
			upd.next_d = wdist;
			upd.second = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			sq_r_s1 <= sq_r;
			sq_g_s1 <= sq_g;
			sq_b_s1 <= sq_b;
			cand_s1 <= in_cand;
		end
		if (load_s2 && valid_s1) begin
			cand_s2 <= upd;
		end
	end

	assign out_valid = valid_s2;
	assign out_cand  = cand_s2;

endmodule

// ===== design/pbd_pick.sv =====
// pbd_pick: dither decision and code lookup at the end of the chain
// threshold test floor(16*next/sum) > t is done as (t+1)*sum <= 16*next
// depends on pbd_pkg
module pbd_pick import pbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cand_t             in_cand,
	input  logic              dither_on,
	input  logic [CODE_W-1:0] codes [PAL_N],
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CODE_W-1:0] panel_code
);

	localparam int PROD_W = THR_W + SUM_W;

	logic              valid_s1, valid_s2;
	logic              load_s1, load_s2;
	logic [SUM_W-1:0]  sum_s1;
	logic [DIST_W-1:0] next_s1;
	logic [THR_W-1:0]  thr_s1;
	logic [IDX_W-1:0]  first_s1, second_s1;
	logic [CODE_W-1:0] code_s2;
	logic [PROD_W-1:0] prod;
	logic              keep_first;
	logic [IDX_W-1:0]  pick;

	assign load_s2  = !valid_s2 || out_ready;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;

	always_comb begin
		prod       = PROD_W'(thr_s1) * PROD_W'(sum_s1);
		keep_first = prod <= PROD_W'({next_s1, 4'b0000});
		pick       = (!dither_on || keep_first) ? first_s1 : second_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			sum_s1    <= SUM_W'(in_cand.best_d) + SUM_W'(in_cand.next_d);
			next_s1   <= in_cand.next_d;
			thr_s1    <= THR_W'(BAYER[in_cand.pix.row_phase][in_cand.pix.col_phase]) + THR_W'(1);
			first_s1  <= in_cand.first;
			second_s1 <= in_cand.second;
		end
		if (load_s2 && valid_s1) begin
			code_s2 <= codes[pick];
		end
	end

	assign out_valid  = valid_s2;
	assign panel_code = code_s2;

endmodule

// ===== design/palette_bayer_dither_mapper.sv =====
// palette_bayer_dither_mapper: rgb pixel to panel color code with 4x4 ordered dither
// top level: config registers, chain of six pbd_cell, pbd_pick output stage
// depends on pbd_pkg, pbd_cell, pbd_pick
//
//   channel   | signals                                     | dir
//   ----------+---------------------------------------------+-----
//   pixel in  | in_valid/in_ready, red green blue col/row   | in
//   code out  | out_valid/out_ready, panel_code             | out
//   config    | cfg_we, cfg_index, cfg_data (write only)    | in
//
// one pixel transfer per cycle sustained while out_ready is held high; 14 register
// stages (two per palette cell, two in the pick stage)
// every stage has its own valid bit and loads when empty or draining, so bubbles
// collapse; with out_ready low the input keeps flowing until all 14 stages hold a pixel
// reset clears the valid bits and loads dither off and the default panel codes
module palette_bayer_dither_mapper import pbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic [1:0]           col_phase,
	input  logic [1:0]           row_phase,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CODE_W-1:0]    panel_code,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// config registers
	logic              dither_on_q;
	logic [CODE_W-1:0] code_q [PAL_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_on_q <= 1'b0;
			for (int i = 0; i < PAL_N; i++) code_q[i] <= CODE_RST[i];
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DITHER: dither_on_q       <= cfg_data[0];
				REG_BLACK:  code_q[0]         <= cfg_data;
				REG_WHITE:  code_q[1]         <= cfg_data;
				REG_YELLOW: code_q[2]         <= cfg_data;
				REG_RED:    code_q[3]         <= cfg_data;
				REG_BLUE:   code_q[4]         <= cfg_data;
				REG_GREEN:  code_q[5]         <= cfg_data;
				default:    ;  // unused index, write dropped
			endcase
		end
	end

	// chain of cells, link i feeds cell i, link PAL_N feeds the pick stage
	logic  link_valid [PAL_N+1];
	logic  link_ready [PAL_N+1];
	cand_t link_cand  [PAL_N+1];

	// seed: no candidate yet, both distances at max so the first entry always wins
	always_comb begin
		link_cand[0].pix.red       = red;
		link_cand[0].pix.green     = green;
		link_cand[0].pix.blue      = blue;
		link_cand[0].pix.col_phase = col_phase;
		link_cand[0].pix.row_phase = row_phase;
		link_cand[0].best_d        = DIST_MAX;
		link_cand[0].next_d        = DIST_MAX;
		link_cand[0].first         = '0;
		link_cand[0].second        = '0;
	end

	assign link_valid[0] = in_valid;
	assign in_ready      = link_ready[0];

	for (genvar k = 0; k < PAL_N; k++) begin : g_cell
		pbd_cell #(.IDX(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_cand   (link_cand[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_cand  (link_cand[k+1])
		);
	end

	// dither decision and code select, output register lives here
	pbd_pick u_pick (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (link_valid[PAL_N]),
		.in_ready   (link_ready[PAL_N]),
		.in_cand    (link_cand[PAL_N]),
		.dither_on  (dither_on_q),
		.codes      (code_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.panel_code (panel_code)
	);

endmodule

// ===== design/pbd_checker.sv =====
// pbd_checker: port level checks for palette_bayer_dither_mapper
// bound to the top level; depends on pbd_pkg
module pbd_checker import pbd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CODE_W-1:0] panel_code
);

	// a stalled code stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(panel_code))
		else $error("panel_code changed while stalled");

	// empty output register means the chain can take a pixel
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with output empty");

	// downstream ready propagates through the whole chain
	a_ready_passes: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

endmodule

bind palette_bayer_dither_mapper pbd_checker u_pbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.panel_code (panel_code)
);
